/* rtl/tun_pkg.sv */
`default_nettype none

package tun_pkg;

    // Width of each unit normal component on the result side.
    localparam int NORMAL_WIDTH = 16;

    // Saturation bounds for a component magnitude.
    localparam logic [NORMAL_WIDTH-1:0] POS_LIMIT = {1'b0, {(NORMAL_WIDTH-1){1'b1}}};
    localparam logic [NORMAL_WIDTH-1:0] NEG_LIMIT = {1'b1, {(NORMAL_WIDTH-1){1'b0}}};

    // Pipeline depth of one cross product lane.
    localparam int CROSS_STAGES = 4;

endpackage

`default_nettype wire

/* rtl/tun_cross.sv */
`default_nettype none

// One cross product component n = p*q - r*s, its magnitude, its sign and
// the square of the magnitude, built from half-width partial products.
module tun_cross #(
    parameter int W = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [W:0]    p,
    input  wire logic signed [W:0]    q,
    input  wire logic signed [W:0]    r,
    input  wire logic signed [W:0]    s,
    output logic [2*W+1:0]            mag,
    output logic                      neg,
    output logic [4*W+3:0]            sq
);

    localparam int PW = 2 * W + 2;
    localparam int MW = 2 * W + 2;
    localparam int H  = W + 1;
    localparam int SQW = 2 * MW;

    logic signed [PW-1:0] prod1_reg, prod2_reg;
    logic signed [PW:0]   diff;
    logic [MW-1:0]        mag_b_next;
    logic [MW-1:0]        mag_b_reg, mag_c_reg, mag_d_reg;
    logic                 neg_b_reg, neg_c_reg, neg_d_reg;
    logic [2*H-1:0]       hh_reg, hl_reg, ll_reg;
    logic [H-1:0]         hi, lo;
    logic [SQW-1:0]       sq_next, sq_reg;

    assign diff = {prod1_reg[PW-1], prod1_reg} - {prod2_reg[PW-1], prod2_reg};
    assign mag_b_next = diff[PW] ? MW'(-diff) : MW'(diff);

    assign hi = mag_b_reg[MW-1:H];
    assign lo = mag_b_reg[H-1:0];

    assign sq_next = (SQW'(hh_reg) << (2 * H)) + (SQW'(hl_reg) << (H + 1)) + SQW'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= PW'(p) * PW'(q);
            prod2_reg <= PW'(r) * PW'(s);
            mag_b_reg <= mag_b_next;
            neg_b_reg <= diff[PW];
            hh_reg    <= (2*H)'(hi) * (2*H)'(hi);
            hl_reg    <= (2*H)'(hi) * (2*H)'(lo);
            ll_reg    <= (2*H)'(lo) * (2*H)'(lo);
            mag_c_reg <= mag_b_reg;
            neg_c_reg <= neg_b_reg;
            sq_reg    <= sq_next;
            mag_d_reg <= mag_c_reg;
            neg_d_reg <= neg_c_reg;
        end
    end

    assign mag = mag_d_reg;
    assign neg = neg_d_reg;
    assign sq  = sq_reg;

endmodule

`default_nettype wire

/* rtl/tun_sqrt.sv */
`default_nettype none

// Pipelined integer square root, one root bit per stage, with a side
// word that travels alongside.
module tun_sqrt #(
    parameter int SW = 70,
    parameter int PW = 8
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [SW-1:0]    rad,
    input  wire logic [PW-1:0]    pass,
    output logic [SW/2-1:0]       root,
    output logic [PW-1:0]         pass_out
);

    localparam int NB = SW / 2;
    localparam int RW = NB + 2;

    logic [RW-1:0] rem_reg  [NB];
    logic [NB-1:0] root_reg [NB];
    logic [SW-1:0] rad_reg  [NB];
    logic [PW-1:0] pass_reg [NB];

    for (genvar j = 0; j < NB; j++)
    begin : g_stage
        logic [RW-1:0] rem_in, sh, tr;
        logic [NB-1:0] root_in;
        logic [SW-1:0] rad_in;
        logic [PW-1:0] pass_in;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign pass_in = pass;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign pass_in = pass_reg[j-1];
        end

        // The remainder never exceeds twice the partial root, so its top
        // two bits are zero before the shift.
        assign sh = {rem_in[RW-3:0], rad_in[SW-1:SW-2]};
        assign tr = {root_in, 2'b01};
        assign ge = (sh >= tr);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? (sh - tr) : sh;
                root_reg[j] <= {root_in[NB-2:0], ge};
                rad_reg[j]  <= {rad_in[SW-3:0], 2'b00};
                pass_reg[j] <= pass_in;
            end
        end
    end

    assign root     = root_reg[NB-1];
    assign pass_out = pass_reg[NB-1];

endmodule

`default_nettype wire

/* rtl/tun_div.sv */
`default_nettype none

// Pipelined restoring divider for one lane: quot = floor(num * 2^F / den),
// valid when num <= den. One quotient bit per stage.
module tun_div #(
    parameter int DW = 35,
    parameter int F  = 14,
    parameter int PW = 2
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DW-1:0]    num,
    input  wire logic [DW-1:0]    den,
    input  wire logic [PW-1:0]    pass,
    output logic [F:0]            quot,
    output logic [PW-1:0]         pass_out
);

    localparam int RW = DW + 1;

    logic [RW-1:0] rem_reg  [F+1];
    logic [F:0]    q_reg    [F+1];
    logic [DW-1:0] den_reg  [F+1];
    logic [PW-1:0] pass_reg [F+1];

    for (genvar j = 0; j <= F; j++)
    begin : g_stage
        logic [RW-1:0] t, d;
        logic [F:0]    q_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pass_in;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign t       = RW'(num);
            assign q_in    = '0;
            assign den_in  = den;
            assign pass_in = pass;
        end
        else
        begin : g_next
            // The remainder stays below the divisor, so doubling it fits.
            assign t       = {rem_reg[j-1][RW-2:0], 1'b0};
            assign q_in    = q_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign pass_in = pass_reg[j-1];
        end

        assign d  = RW'(den_in);
        assign ge = (t >= d);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? (t - d) : t;
                q_reg[j]    <= {q_in[F-1:0], ge};
                den_reg[j]  <= den_in;
                pass_reg[j] <= pass_in;
            end
        end
    end

    assign quot     = q_reg[F];
    assign pass_out = pass_reg[F];

endmodule

`default_nettype wire

/* rtl/triangle_unit_normal.sv */
`default_nettype none

// Channel  Direction  Word contents
// s_axis   in         tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z
// m_axis   out        tdata: normal_x normal_y normal_z; tuser: degenerate
//
// One triangle enters per cycle while no output word waits untaken. The stages
// are the edge register, four cross product stages, the merge adder, one
// square root stage per root bit, one divider stage per quotient bit and the
// output register.
// Reset clears only the valid pipeline. When the output word is not taken
// the whole pipeline holds, and s_axis_tready falls in the same cycle.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // normal_x, normal_y, normal_z from bit 0 up
    output logic [3*tun_pkg::NORMAL_WIDTH-1:0]          m_axis_tdata,
    // degenerate
    output logic [0:0]                                  m_axis_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int NW  = tun_pkg::NORMAL_WIDTH;
    localparam int MW  = 2 * W + 2;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    localparam int NB  = SW / 2;
    localparam int QW  = F + 1;
    localparam int QX  = (QW > NW + 1) ? QW : NW + 1;
    localparam int PSW = 3 * MW + 4;
    localparam int LAT = 1 + tun_pkg::CROSS_STAGES + 1 + NB + QW + 1;

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // Edge vectors e1 = a - b and e2 = a - c.
    logic signed [W:0] e1_reg [3];
    logic signed [W:0] e2_reg [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_edge
        logic signed [W-1:0] a, b, c;
        assign a = s_axis_tdata[k*W +: W];
        assign b = s_axis_tdata[(3+k)*W +: W];
        assign c = s_axis_tdata[(6+k)*W +: W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e1_reg[k] <= (W+1)'(a) - (W+1)'(b);
                e2_reg[k] <= (W+1)'(a) - (W+1)'(c);
            end
        end
    end

    logic [MW-1:0]  mag  [3];
    logic           neg  [3];
    logic [SQW-1:0] sq   [3];

    tun_cross #(.W(W)) u_cross_x (
        .clk(clk), .en(en),
        .p(e1_reg[1]), .q(e2_reg[2]), .r(e1_reg[2]), .s(e2_reg[1]),
        .mag(mag[0]), .neg(neg[0]), .sq(sq[0])
    );

    tun_cross #(.W(W)) u_cross_y (
        .clk(clk), .en(en),
        .p(e1_reg[2]), .q(e2_reg[0]), .r(e1_reg[0]), .s(e2_reg[2]),
        .mag(mag[1]), .neg(neg[1]), .sq(sq[1])
    );

    tun_cross #(.W(W)) u_cross_z (
        .clk(clk), .en(en),
        .p(e1_reg[0]), .q(e2_reg[1]), .r(e1_reg[1]), .s(e2_reg[0]),
        .mag(mag[2]), .neg(neg[2]), .sq(sq[2])
    );

    // Merge: squared length and the side word for the root pipeline.
    logic [SW-1:0]  sum_reg;
    logic [PSW-1:0] side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
            side_reg <= {((mag[0] | mag[1] | mag[2]) == '0),
                         neg[2], neg[1], neg[0], mag[2], mag[1], mag[0]};
        end
    end

    logic [NB-1:0]  len;
    logic [PSW-1:0] side;

    tun_sqrt #(.SW(SW), .PW(PSW)) u_sqrt (
        .clk(clk), .en(en),
        .rad(sum_reg), .pass(side_reg),
        .root(len), .pass_out(side)
    );

    logic              degen;
    logic [QW-1:0]     quot  [3];
    logic [1:0]        dpass [3];
    logic [NW-1:0]     comp  [3];

    assign degen = side[PSW-1];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [QX-1:0] qx;
        logic [NW-1:0] pos_val, neg_mag;

        tun_div #(.DW(NB), .F(F), .PW(2)) u_div (
            .clk(clk), .en(en),
            .num(NB'(side[k*MW +: MW])), .den(len),
            .pass({degen, side[3*MW+k]}),
            .quot(quot[k]), .pass_out(dpass[k])
        );

        assign qx      = QX'(quot[k]);
        assign pos_val = (qx > QX'(tun_pkg::POS_LIMIT)) ? tun_pkg::POS_LIMIT : qx[NW-1:0];
        assign neg_mag = (qx > QX'(tun_pkg::NEG_LIMIT)) ? tun_pkg::NEG_LIMIT : qx[NW-1:0];

        always_comb
        begin
            if (dpass[k][1])
                comp[k] = '0;
            else if (dpass[k][0])
                comp[k] = -neg_mag;
            else
                comp[k] = pos_val;
        end
    end

    logic [3*NW-1:0] data_reg;
    logic            degen_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg  <= {comp[2], comp[1], comp[0]};
            degen_reg <= dpass[0][1];
        end
    end

    assign m_axis_tdata = data_reg;
    assign m_axis_tuser = degen_reg;

endmodule

`default_nettype wire

/* dv/triangle_unit_normal_tb.sv */
`default_nettype none

module triangle_unit_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int FRAC = 14;
    localparam int NW = tun_pkg::NORMAL_WIDTH;
    localparam int IN_W = ((9 * CW + 7) / 8) * 8;
    localparam int LATENCY = 2 * CW + FRAC + 11;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [NW-1:0] nz;
        logic [NW-1:0] ny;
        logic [NW-1:0] nx;
        logic          degen;
    } normal_t;

    class normal_scoreboard;
        normal_t expected_normals[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // Exact integer square root of a sum of squares.
        function logic [127:0] isqrt(logic [127:0] n);
            logic [127:0] root;
            logic [127:0] trial;
            root = '0;
            for (int i = 63; i >= 0; i--)
            begin
                trial = root | (128'd1 << i);
                if (trial * trial <= n)
                    root = trial;
            end
            return root;
        endfunction

        function void note_triangle(logic [IN_W-1:0] d);
            longint       v[9];
            longint       e1[3];
            longint       e2[3];
            longint       cr[3];
            logic [127:0] mag[3];
            logic [127:0] sum;
            logic [127:0] len;
            logic [127:0] q;
            longint       s;
            normal_t      r;
            for (int k = 0; k < 9; k++)
                v[k] = longint'($signed(d[k*CW +: CW]));
            for (int k = 0; k < 3; k++)
            begin
                e1[k] = v[k] - v[3+k];
                e2[k] = v[k] - v[6+k];
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            sum = '0;
            for (int k = 0; k < 3; k++)
            begin
                mag[k] = (cr[k] < 0) ? 128'(-cr[k]) : 128'(cr[k]);
                sum += mag[k] * mag[k];
            end
            r = '0;
            if (sum == 0)
                r.degen = 1'b1;
            else
            begin
                len = isqrt(sum);
                for (int k = 0; k < 3; k++)
                begin
                    q = (mag[k] << FRAC) / len;
                    if (q > 128'd32768)
                        q = 128'd32768;
                    s = (cr[k] < 0) ? -longint'(q) : longint'(q);
                    if (s > 32767)
                        s = 32767;
                    if (k == 0) r.nx = s[NW-1:0];
                    if (k == 1) r.ny = s[NW-1:0];
                    if (k == 2) r.nz = s[NW-1:0];
                end
            end
            expected_normals.push_back(r);
        endfunction

        function void check_normal(logic [3*NW-1:0] d, logic degen);
            normal_t got;
            normal_t exp_n;
            got = {d[2*NW +: NW], d[NW +: NW], d[0 +: NW], degen};
            if (expected_normals.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $realtime, got);
                errors++;
                return;
            end
            exp_n = expected_normals.pop_front();
            if (got.nx !== exp_n.nx)
            begin
                $display("%0t: normal_x expected %h actual %h", $realtime, exp_n.nx, got.nx);
                errors++;
            end
            if (got.ny !== exp_n.ny)
            begin
                $display("%0t: normal_y expected %h actual %h", $realtime, exp_n.ny, got.ny);
                errors++;
            end
            if (got.nz !== exp_n.nz)
            begin
                $display("%0t: normal_z expected %h actual %h", $realtime, exp_n.nz, got.nz);
                errors++;
            end
            if (got.degen !== exp_n.degen)
            begin
                $display("%0t: degenerate expected %b actual %b", $realtime,
                         exp_n.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [3*NW-1:0]   m_axis_tdata;    // normal_x, normal_y, normal_z
    logic [0:0]        m_axis_tuser;    // degenerate

    normal_scoreboard  sb;
    int                idle_cycles;
    bit                sender_no_idle;

    triangle_unit_normal #(
        .COORD_WIDTH(CW),
        .NORMAL_FRAC_BITS(FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_triangle(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_normal(m_axis_tdata, m_axis_tuser[0]);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver counts its own cycles: a long hold-off early on, then a stretch
    // that always takes words, random stalls elsewhere.
    initial
    begin
        int cyc;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        cyc = 0;
        forever
        begin
            if (cyc >= 600 && cyc < 1000)
                m_axis_tready <= 1'b0;
            else if (cyc >= 1600 && cyc < 2400)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 32);
            @(posedge clk);
            cyc++;
        end
    end

    function automatic logic [IN_W-1:0] pack_triangle(longint v[9]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++)
            d[k*CW +: CW] = v[k][CW-1:0];
        return d;
    endfunction

    // Each cycle idles with the same odds, about a third, unless sender_no_idle is set.
    task automatic send_triangle(logic [IN_W-1:0] d);
        while (!sender_no_idle && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_coords(longint v[9]);
        send_triangle(pack_triangle(v));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_normals.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        longint v[9];
        longint d[3];
        int     kind;
        sb = new();
        idle_cycles = 0;
        sender_no_idle = 1'b0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coincident vertices, extremes, axis-aligned faces, collinear points.
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_coords(v);
        v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_coords(v);
        v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_coords(v);
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        send_coords(v);
        v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        send_coords(v);
        v = '{0, 0, 0, 0, 0, 256, 0, 256, 0};
        send_coords(v);
        v = '{0, 0, 0, 256, 0, 0, 0, 0, 256};
        send_coords(v);
        v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        send_coords(v);
        v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        send_coords(v);
        v = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768};
        send_coords(v);
        v = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767};
        send_coords(v);
        v = '{100, 200, 300, 200, 400, 600, 300, 600, 900};
        send_coords(v);
        v = '{-5, 7, 9, -5, 7, 9, 1000, -2000, 300};
        send_coords(v);
        v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_coords(v);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_coords(v);
        v = '{0, 0, 0, 32767, 1, 0, -32768, 1, 0};
        send_coords(v);
        v = '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0};
        send_coords(v);
        v = '{10, 10, 10, 10, 10, 10, 11, 10, 10};
        send_coords(v);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_no_idle = (n >= 900 && n < 1300);
            if (n == 1400)
                drain();
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                for (int k = 0; k < 9; k++)
                    v[k] = longint'($signed(16'($urandom())));
            end
            else if (kind < 75)
            begin
                for (int k = 0; k < 9; k++)
                    v[k] = longint'($urandom_range(1024)) - 512;
            end
            else if (kind < 90)
            begin
                // Collinear or coincident vertices give a zero cross product.
                for (int k = 0; k < 3; k++)
                begin
                    v[k] = longint'($urandom_range(8000)) - 4000;
                    d[k] = longint'($urandom_range(200)) - 100;
                    if ($urandom_range(3) == 0)
                        d[k] = 0;
                    v[3+k] = v[k] + d[k];
                    v[6+k] = v[k] - 3 * d[k];
                end
            end
            else
            begin
                // Thin slivers: nearly collinear, one small offset.
                for (int k = 0; k < 3; k++)
                begin
                    v[k] = longint'($urandom_range(8000)) - 4000;
                    d[k] = longint'($urandom_range(200)) - 100;
                    v[3+k] = v[k] + d[k];
                    v[6+k] = v[k] + 2 * d[k];
                end
                v[6 + $urandom_range(2)] += 1;
            end
            send_coords(v);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_normals.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_normals.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_sqrt.sv
rtl/tun_div.sv
rtl/triangle_unit_normal.sv
dv/triangle_unit_normal_tb.sv
